[src/gtcb_pkg.sv]
// Shared types and constants of the gated timer counter bank.
package gtcb_pkg;

	localparam int NUM_CH = 3;
	localparam int CW     = 16;

	typedef enum logic [2:0] {
		OP_CPU_TICK = 3'd0,
		OP_DOT_TICK = 3'd1,
		OP_HBLANK   = 3'd2,
		OP_VBLANK   = 3'd3,
		OP_WRITE    = 3'd4,
		OP_READ     = 3'd5
	} op_t;

	localparam logic [1:0] REG_COUNT  = 2'd0;
	localparam logic [1:0] REG_MODE   = 2'd1;
	localparam logic [1:0] REG_TARGET = 2'd2;

	localparam logic [1:0] SYNC_PAUSE   = 2'd0;
	localparam logic [1:0] SYNC_RST_LOW = 2'd1;
	localparam logic [1:0] SYNC_RST_HI  = 2'd2;
	localparam logic [1:0] SYNC_RELEASE = 2'd3;

	localparam int B_SYNC_EN = 0;
	localparam int B_RST_TGT = 3;
	localparam int B_IRQ_TGT = 4;
	localparam int B_IRQ_MAX = 5;
	localparam int B_REPEAT  = 6;
	localparam int B_TOGGLE  = 7;
	localparam int B_IRQ_REQ = 10;
	localparam int B_HIT_TGT = 11;
	localparam int B_HIT_MAX = 12;

	localparam logic [CW-1:0] WR_MASK  = 16'he3ff;
	localparam logic [CW-1:0] CNT_MAX  = 16'hffff;
	localparam logic [CW-1:0] CNT_PMAX = 16'hfffe;

	typedef struct packed {
		logic [CW-1:0] count;
		logic [CW-1:0] mode;
		logic [CW-1:0] target;
		logic          fired;
	} tmr_state_t;

	typedef struct packed {
		logic [CW-1:0] count;
		logic [CW-1:0] mode;
		logic          fired;
		logic          irq;
	} tick_res_t;

endpackage

[src/gtcb_tick.sv]
// One-tick advance of a single timer: count, reached flags and interrupt.
module gtcb_tick (
	input  logic                   en,
	input  gtcb_pkg::tmr_state_t   st,
	output gtcb_pkg::tick_res_t    res
);
	import gtcb_pkg::*;

	logic [CW-1:0] cnt1;
	logic          hit_t;
	logic          hit_m;
	logic          irq_t;
	logic          irq_m;
	logic [1:0]    ev;
	logic [CW-1:0] mode_a;

	always_comb begin
		cnt1   = st.count + 16'd1;
		hit_t  = (st.target == cnt1);
		hit_m  = (st.count == CNT_PMAX);
		irq_t  = hit_t && st.mode[B_IRQ_TGT];
		irq_m  = hit_m && st.mode[B_IRQ_MAX];
		mode_a = st.mode;
		mode_a[B_HIT_TGT] = st.mode[B_HIT_TGT] | hit_t;
		mode_a[B_HIT_MAX] = st.mode[B_HIT_MAX] | hit_m;
		if ((st.target == CNT_MAX) && irq_t && irq_m) begin
			ev = 2'd1;
		end else begin
			ev = {1'b0, irq_t} + {1'b0, irq_m};
		end
		if (!st.mode[B_REPEAT] && ev != 2'd0) begin
			ev = 2'd1;
		end

		res.count = st.count;
		res.mode  = st.mode;
		res.fired = st.fired;
		res.irq   = 1'b0;
		if (en) begin
			res.count = (hit_t && st.mode[B_RST_TGT]) ? '0 : cnt1;
			res.mode  = mode_a;
			if (ev != 2'd0 && (st.mode[B_REPEAT] || !st.fired)) begin
				res.fired = 1'b1;
				if (st.mode[B_TOGGLE]) begin
					res.irq = st.mode[B_IRQ_REQ] || (ev > 2'd1);
					if (ev[0]) begin
						res.mode[B_IRQ_REQ] = ~st.mode[B_IRQ_REQ];
					end
				end else begin
					res.irq = 1'b1;
					res.mode[B_IRQ_REQ] = 1'b1;
				end
			end
		end
	end

endmodule

[src/gated_timer_counter_bank_core.sv]
// Top level of the gated timer counter bank: input stage, timer state and result register.
//
// Usage: each input item is a CPU tick, a dot tick, an hblank or vblank level,
// or a register write or read for one of three 16-bit timers. Every item gives
// exactly one result item: read_data (register value on a read, zero otherwise)
// and irq_mask (one bit per timer that raised its interrupt on this item).
// Both channels use valid/ready. An accepted item is held in the input
// register; the timer state is updated and the result registered as it leaves.
// Throughput is one item per cycle while the receiver is ready: the whole
// update of all three timers is a single pass of logic between the input
// register and the result register. When the receiver stalls, the result
// register holds and the input register keeps one more item; in_ready drops
// only while both are full. Reset clears all counters, modes, targets, the
// prescaler phase, the one-shot and gate flags and the gate levels, and
// empties both registers.
module gated_timer_counter_bank_core #(
	parameter int PRESCALE = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [1:0]  channel,
	input  logic [1:0]  reg_sel,
	input  logic [15:0] write_data,
	input  logic        blank_level,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] read_data,
	output logic [2:0]  irq_mask
);
	import gtcb_pkg::*;

	localparam int PW = $clog2(PRESCALE);

	logic          valid_s1;
	logic [2:0]    mode_s1;
	logic [1:0]    channel_s1;
	logic [1:0]    reg_sel_s1;
	logic [CW-1:0] write_data_s1;
	logic          blank_level_s1;

	logic          out_valid_q;
	logic [CW-1:0] read_data_q;
	logic [2:0]    irq_mask_q;

	logic [CW-1:0] count_q    [NUM_CH];
	logic [CW-1:0] mode_q     [NUM_CH];
	logic [CW-1:0] target_q   [NUM_CH];
	logic          fired_q    [NUM_CH];
	logic          released_q [2];
	logic          gate_q     [2];
	logic [PW-1:0] phase_q;

	logic [CW-1:0] count_n    [NUM_CH];
	logic [CW-1:0] mode_n     [NUM_CH];
	logic [CW-1:0] target_n   [NUM_CH];
	logic          fired_n    [NUM_CH];
	logic          released_n [2];
	logic          gate_n     [2];
	logic [PW-1:0] phase_n;
	logic [CW-1:0] rd_n;
	logic [2:0]    irq_n;

	logic          advance;
	logic          work;
	op_t           op;
	logic          may [NUM_CH];
	logic          tick_en [NUM_CH];
	logic [PW:0]   phase_inc;
	logic          pre_count;
	logic          gate_chg;
	logic          fall;

	tmr_state_t    st [NUM_CH];
	tick_res_t     tr [NUM_CH];

	assign advance  = !out_valid_q || out_ready;
	assign work     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;
	assign op       = op_t'(mode_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1        <= mode;
			channel_s1     <= channel;
			reg_sel_s1     <= reg_sel;
			write_data_s1  <= write_data;
			blank_level_s1 <= blank_level;
		end
	end

	always_comb begin
		for (int c = 0; c < 2; c++) begin
			case (mode_q[c][2:1])
				SYNC_PAUSE:   may[c] = !gate_q[c];
				SYNC_RST_LOW: may[c] = 1'b1;
				SYNC_RST_HI:  may[c] = gate_q[c];
				default:      may[c] = gate_q[c] || released_q[c];
			endcase
			if (!mode_q[c][B_SYNC_EN]) begin
				may[c] = 1'b1;
			end
		end
		may[2] = !mode_q[2][B_SYNC_EN] || (mode_q[2][2:1] == SYNC_RST_LOW)
			|| (mode_q[2][2:1] == SYNC_RST_HI);

		phase_inc = {1'b0, phase_q} + {{PW{1'b0}}, 1'b1};
		pre_count = (op == OP_CPU_TICK) && may[2] && mode_q[2][9];
		gate_chg  = (op == OP_HBLANK) ? (gate_q[0] != blank_level_s1)
			: (gate_q[1] != blank_level_s1);

		tick_en[0] = may[0] && (((op == OP_CPU_TICK) && !mode_q[0][8])
			|| ((op == OP_DOT_TICK) && mode_q[0][8]));
		tick_en[1] = may[1] && (((op == OP_CPU_TICK) && !mode_q[1][8])
			|| ((op == OP_HBLANK) && gate_chg && blank_level_s1 && mode_q[1][8]));
		tick_en[2] = (op == OP_CPU_TICK) && may[2]
			&& (!mode_q[2][9] || (phase_inc >= (PW+1)'(PRESCALE)));
	end

	for (genvar g = 0; g < NUM_CH; g++) begin : g_tick
		assign st[g].count  = count_q[g];
		assign st[g].mode   = mode_q[g];
		assign st[g].target = target_q[g];
		assign st[g].fired  = fired_q[g];
		gtcb_tick u_tick (
			.en  (tick_en[g]),
			.st  (st[g]),
			.res (tr[g])
		);
	end

	always_comb begin
		rd_n  = '0;
		irq_n = '0;
		fall  = !blank_level_s1;
		for (int c = 0; c < NUM_CH; c++) begin
			count_n[c]  = tr[c].count;
			mode_n[c]   = tr[c].mode;
			fired_n[c]  = tr[c].fired;
			target_n[c] = target_q[c];
			irq_n[c]    = tr[c].irq;
		end
		for (int c = 0; c < 2; c++) begin
			released_n[c] = released_q[c];
			gate_n[c]     = gate_q[c];
		end
		phase_n = phase_q;
		if (pre_count) begin
			phase_n = (phase_inc >= (PW+1)'(PRESCALE)) ? '0 : phase_inc[PW-1:0];
		end

		// apply the gate edge
		for (int c = 0; c < 2; c++) begin
			if (gate_chg && (((c == 0) && (op == OP_HBLANK)) || ((c == 1) && (op == OP_VBLANK))))
			begin
				gate_n[c] = blank_level_s1;
				if (mode_q[c][B_SYNC_EN]) begin
					case (mode_q[c][2:1])
						SYNC_RST_LOW: if (fall) count_n[c] = '0;
						SYNC_RST_HI:  if (!fall) count_n[c] = '0;
						SYNC_RELEASE: if (fall) released_n[c] = 1'b1;
						default:      ;
					endcase
				end
			end
		end

		for (int c = 0; c < NUM_CH; c++) begin
			if (channel_s1 == 2'(c)) begin
				if (op == OP_WRITE) begin
					case (reg_sel_s1)
						REG_COUNT:  count_n[c] = write_data_s1;
						REG_MODE: begin
							count_n[c] = '0;
							mode_n[c]  = write_data_s1 & WR_MASK;
							mode_n[c][B_IRQ_REQ] = 1'b1;
							fired_n[c] = 1'b0;
							if (c < 2) begin
								released_n[c % 2] = 1'b0;
							end else begin
								phase_n = '0;
							end
						end
						REG_TARGET: target_n[c] = write_data_s1;
						default:    ;
					endcase
				end else if (op == OP_READ) begin
					case (reg_sel_s1)
						REG_COUNT:  rd_n = count_q[c];
						REG_MODE: begin
							rd_n = mode_q[c];
							mode_n[c][B_HIT_TGT] = 1'b0;
							mode_n[c][B_HIT_MAX] = 1'b0;
						end
						REG_TARGET: rd_n = target_q[c];
						default:    ;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NUM_CH; c++) begin
				count_q[c]  <= '0;
				mode_q[c]   <= '0;
				target_q[c] <= '0;
				fired_q[c]  <= 1'b0;
			end
			for (int c = 0; c < 2; c++) begin
				released_q[c] <= 1'b0;
				gate_q[c]     <= 1'b0;
			end
			phase_q <= '0;
		end else if (work) begin
			for (int c = 0; c < NUM_CH; c++) begin
				count_q[c]  <= count_n[c];
				mode_q[c]   <= mode_n[c];
				target_q[c] <= target_n[c];
				fired_q[c]  <= fired_n[c];
			end
			for (int c = 0; c < 2; c++) begin
				released_q[c] <= released_n[c];
				gate_q[c]     <= gate_n[c];
			end
			phase_q <= phase_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (work) begin
			read_data_q <= rd_n;
			irq_mask_q  <= irq_n;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign irq_mask  = irq_mask_q;

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, phase_q} < (PW+1)'(PRESCALE))
		else $error("prescaler phase out of range");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stage stalled without a held result");

	a_read_no_irq: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && irq_mask != 3'd0) |-> (read_data == 16'd0))
		else $error("interrupt raised on a read item");

	a_mode_write: assert property (@(posedge clk) disable iff (!arst_n)
		(work && op == OP_WRITE && reg_sel_s1 == REG_MODE && channel_s1 == 2'd0)
		|=> (mode_q[0][B_IRQ_REQ] && count_q[0] == '0 && !fired_q[0]))
		else $error("mode write did not reinitialise the timer");

endmodule

[tb/gtcb_checker.sv]
`timescale 1ns / 1ps
// Timer bank checker: predicts each result from the accepted items and compares it.
module gtcb_checker #(
	parameter int PRESCALE = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [1:0]  channel,
	input  logic [1:0]  reg_sel,
	input  logic [15:0] write_data,
	input  logic        blank_level,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] read_data,
	input  logic [2:0]  irq_mask,
	output int          fail_count,
	output int          outstanding
);
	import gtcb_pkg::*;

	localparam int B_CLK_EXT   = 8;
	localparam int B_CLK_DIV   = 9;
	localparam int MAX_REPORTS = 40;

	typedef struct packed {
		logic [CW-1:0] rd;
		logic [2:0]    irq;
	} timer_result_t;

	logic [CW-1:0] t_count    [NUM_CH];
	logic [CW-1:0] t_mode     [NUM_CH];
	logic [CW-1:0] t_target   [NUM_CH];
	bit            t_fired    [NUM_CH];
	bit            t_released [NUM_CH];
	bit            blank_lvl  [2];
	int            prescale_cnt;
	timer_result_t due_results [$];

	function automatic bit gate_open(int c);
		logic [1:0] s;
		s = t_mode[c][2:1];
		if (!t_mode[c][B_SYNC_EN])
			return 1'b1;
		if (c == NUM_CH - 1)
			return s == SYNC_RST_LOW || s == SYNC_RST_HI;
		case (s)
			SYNC_PAUSE:   return !blank_lvl[c];
			SYNC_RST_LOW: return 1'b1;
			SYNC_RST_HI:  return blank_lvl[c];
			default:      return blank_lvl[c] || t_released[c];
		endcase
	endfunction

	function automatic logic [2:0] signal_irq(int c, int events);
		logic [2:0] bit_c;
		bit         was_high;
		bit_c = 3'b001 << c;
		if (events == 0)
			return 3'b000;
		if (!t_mode[c][B_REPEAT] && t_fired[c])
			return 3'b000;
		t_fired[c] = 1'b1;
		if (!t_mode[c][B_REPEAT])
			events = 1;
		if (t_mode[c][B_TOGGLE]) begin
			was_high = t_mode[c][B_IRQ_REQ];
			if (events[0])
				t_mode[c][B_IRQ_REQ] = !t_mode[c][B_IRQ_REQ];
			return (was_high || events > 1) ? bit_c : 3'b000;
		end
		t_mode[c][B_IRQ_REQ] = 1'b1;
		return bit_c;
	endfunction

	function automatic logic [2:0] count_one(int c);
		logic [CW-1:0] nxt;
		bit            hit_t, hit_m, irq_t, irq_m;
		int            ev;
		nxt   = t_count[c] + 16'd1;
		hit_t = t_target[c] == nxt;
		hit_m = t_count[c] == CNT_PMAX;
		if (hit_t)
			t_mode[c][B_HIT_TGT] = 1'b1;
		if (hit_m)
			t_mode[c][B_HIT_MAX] = 1'b1;
		t_count[c] = (hit_t && t_mode[c][B_RST_TGT]) ? '0 : nxt;
		irq_t = hit_t && t_mode[c][B_IRQ_TGT];
		irq_m = hit_m && t_mode[c][B_IRQ_MAX];
		if (t_target[c] == CNT_MAX && irq_t && irq_m)
			ev = 1;
		else
			ev = int'(irq_t) + int'(irq_m);
		return signal_irq(c, ev);
	endfunction

	function automatic void move_gate(int c, bit lvl);
		bit rise, fall;
		rise = !blank_lvl[c] && lvl;
		fall = blank_lvl[c] && !lvl;
		blank_lvl[c] = lvl;
		if (!t_mode[c][B_SYNC_EN])
			return;
		case (t_mode[c][2:1])
			SYNC_RST_LOW: if (fall) t_count[c] = '0;
			SYNC_RST_HI:  if (rise) t_count[c] = '0;
			SYNC_RELEASE: if (fall) t_released[c] = 1'b1;
			default: ;
		endcase
	endfunction

	function automatic logic [2:0] cpu_cycle();
		logic [2:0] irq;
		irq = 3'b000;
		for (int k = 0; k < 2; k++)
			if (!t_mode[k][B_CLK_EXT] && gate_open(k))
				irq |= count_one(k);
		if (!gate_open(NUM_CH - 1))
			return irq;
		if (!t_mode[NUM_CH - 1][B_CLK_DIV])
			return irq | count_one(NUM_CH - 1);
		prescale_cnt++;
		if (prescale_cnt >= PRESCALE) begin
			prescale_cnt = 0;
			irq |= count_one(NUM_CH - 1);
		end
		return irq;
	endfunction

	function automatic timer_result_t apply_item(logic [2:0] op, logic [1:0] ch, logic [1:0] rs,
			logic [CW-1:0] wd, logic lvl);
		timer_result_t r;
		r.rd  = '0;
		r.irq = 3'b000;
		case (op)
			OP_CPU_TICK: r.irq = cpu_cycle();
			OP_DOT_TICK: if (t_mode[0][B_CLK_EXT] && gate_open(0)) r.irq = count_one(0);
			OP_HBLANK: begin
				if (blank_lvl[0] != lvl) begin
					move_gate(0, lvl);
					if (lvl && t_mode[1][B_CLK_EXT] && gate_open(1))
						r.irq = count_one(1);
				end
			end
			OP_VBLANK: if (blank_lvl[1] != lvl) move_gate(1, lvl);
			OP_WRITE: begin
				if (ch < NUM_CH) begin
					case (rs)
						REG_COUNT:  t_count[ch] = wd;
						REG_MODE: begin
							t_count[ch] = '0;
							t_mode[ch]  = (wd & WR_MASK) | (16'd1 << B_IRQ_REQ);
							if (ch == NUM_CH - 1)
								prescale_cnt = 0;
							t_fired[ch]    = 1'b0;
							t_released[ch] = 1'b0;
						end
						REG_TARGET: t_target[ch] = wd;
						default: ;
					endcase
				end
			end
			OP_READ: begin
				if (ch < NUM_CH) begin
					case (rs)
						REG_COUNT:  r.rd = t_count[ch];
						REG_MODE: begin
							r.rd = t_mode[ch];
							t_mode[ch][B_HIT_TGT] = 1'b0;
							t_mode[ch][B_HIT_MAX] = 1'b0;
						end
						REG_TARGET: r.rd = t_target[ch];
						default: ;
					endcase
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
		if (fail_count < MAX_REPORTS)
			$display("%0t: %s mismatch: got %h, want %h", $time, what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		timer_result_t want;
		if (!arst_n) begin
			for (int c = 0; c < NUM_CH; c++) begin
				t_count[c]    = '0;
				t_mode[c]     = '0;
				t_target[c]   = '0;
				t_fired[c]    = 1'b0;
				t_released[c] = 1'b0;
			end
			blank_lvl[0] = 1'b0;
			blank_lvl[1] = 1'b0;
			prescale_cnt = 0;
			due_results.delete();
			outstanding = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					report_mismatch("unexpected result", read_data, '0);
				end else begin
					want = due_results.pop_front();
					if (read_data !== want.rd)
						report_mismatch("read_data", read_data, want.rd);
					if (irq_mask !== want.irq)
						report_mismatch("irq_mask", CW'(irq_mask), CW'(want.irq));
				end
			end
			if (in_valid && in_ready)
				due_results.push_back(apply_item(mode, channel, reg_sel, write_data, blank_level));
			outstanding = due_results.size();
		end
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Timer bank testbench top: clock, reset, item stimulus, output stalls and the final verdict.
module tb;
	import gtcb_pkg::*;

	localparam int N_ITEMS   = 900;
	localparam int LONG_HOLD = 300;
	localparam int HOLD_AT   = 400;

	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [1:0] CH_NONE    = 2'd3;
	localparam logic [1:0] REG_NONE   = 2'd3;

	localparam logic [CW-1:0] SRC_EXT = 16'h0100;
	localparam logic [CW-1:0] SRC_DIV = 16'h0200;
	localparam logic [CW-1:0] BOTH_IRQ_RPT = (16'd1 << B_IRQ_TGT) | (16'd1 << B_IRQ_MAX)
		| (16'd1 << B_REPEAT);
	localparam logic [CW-1:0] TOGGLE_RST = (16'd1 << B_IRQ_TGT) | (16'd1 << B_RST_TGT)
		| (16'd1 << B_REPEAT) | (16'd1 << B_TOGGLE) | SRC_EXT;
	localparam logic [CW-1:0] PULSE_RST_DIV = (16'd1 << B_IRQ_TGT) | (16'd1 << B_RST_TGT)
		| (16'd1 << B_REPEAT) | SRC_DIV;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  mode;
	logic [1:0]  channel;
	logic [1:0]  reg_sel;
	logic [15:0] write_data;
	logic        blank_level;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] read_data;
	logic [2:0]  irq_mask;

	int fail_count;
	int outstanding;
	int items_sent;
	int calm_items;

	gated_timer_counter_bank_core #(.PRESCALE(8)) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.channel     (channel),
		.reg_sel     (reg_sel),
		.write_data  (write_data),
		.blank_level (blank_level),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.read_data   (read_data),
		.irq_mask    (irq_mask)
	);

	gtcb_checker #(.PRESCALE(8)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.channel     (channel),
		.reg_sel     (reg_sel),
		.write_data  (write_data),
		.blank_level (blank_level),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.read_data   (read_data),
		.irq_mask    (irq_mask),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#4_000_000;
		$display("Regression FAIL");
		$finish;
	end

	function automatic int next_gap();
		int r;
		if (calm_items > 0) begin
			calm_items--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2)
			calm_items = 40;
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic offer(logic [2:0] op, logic [1:0] ch, logic [1:0] rs, logic [15:0] wd,
			logic lvl);
		int gap;
		in_valid    <= 1'b1;
		mode        <= op;
		channel     <= ch;
		reg_sel     <= rs;
		write_data  <= wd;
		blank_level <= lvl;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (op <= OP_READ && !(op == OP_WRITE && (ch == CH_NONE || rs == REG_NONE)))
			items_sent++;
		gap = next_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic offer_op(logic [2:0] op, logic lvl);
		offer(op, 2'($urandom), 2'($urandom), 16'($urandom), lvl);
	endtask

	task automatic write_reg(logic [1:0] ch, logic [1:0] rs, logic [15:0] wd);
		offer(OP_WRITE, ch, rs, wd, 1'($urandom));
	endtask

	task automatic read_reg(logic [1:0] ch, logic [1:0] rs);
		offer(OP_READ, ch, rs, 16'($urandom), 1'($urandom));
	endtask

	task automatic timer_scenario();
		logic [1:0]    c;
		logic [CW-1:0] tg;
		int            r, len;
		c = 2'($urandom_range(0, NUM_CH - 1));
		write_reg(c, REG_MODE, 16'($urandom));
		r = $urandom_range(0, 3);
		case (r)
			0:       tg = CNT_MAX;
			1:       tg = CW'($urandom_range(1, 12));
			2:       tg = '0;
			default: tg = CW'($urandom);
		endcase
		write_reg(c, REG_TARGET, tg);
		r = $urandom_range(0, 2);
		if (r == 0)
			write_reg(c, REG_COUNT, CW'(tg - $urandom_range(1, 10)));
		else if (r == 1)
			write_reg(c, REG_COUNT, CW'(CNT_MAX - $urandom_range(0, 10)));
		len = $urandom_range(4, 40);
		repeat (len) begin
			r = $urandom_range(0, 99);
			if (r < 50)
				offer_op(OP_CPU_TICK, 1'($urandom));
			else if (r < 62)
				offer_op(OP_DOT_TICK, 1'($urandom));
			else if (r < 77)
				offer_op(OP_HBLANK, 1'($urandom));
			else if (r < 87)
				offer_op(OP_VBLANK, 1'($urandom));
			else if (r < 95)
				read_reg(2'($urandom_range(0, NUM_CH - 1)), 2'($urandom_range(0, 2)));
			else
				write_reg(2'($urandom_range(0, NUM_CH - 1)), 2'($urandom_range(0, 2)),
					16'($urandom));
		end
		read_reg(c, REG_MODE);
		read_reg(c, REG_COUNT);
	endtask

	initial begin : sink
		int stall, calm, cycles, r;
		stall  = 0;
		calm   = 0;
		cycles = 0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (cycles == HOLD_AT) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (calm > 0) begin
				calm--;
				out_ready <= 1'b1;
			end else if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 2)
					calm = 60;
				else if (r < 10)
					stall = $urandom_range(1, 3);
				else if (r < 12)
					stall = $urandom_range(10, 40);
				out_ready <= 1'b1;
			end
			cycles++;
			@(posedge clk);
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		mode        = OP_CPU_TICK;
		channel     = '0;
		reg_sel     = '0;
		write_data  = '0;
		blank_level = 1'b0;
		items_sent  = 0;
		calm_items  = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(2'd0, REG_MODE, BOTH_IRQ_RPT);
		write_reg(2'd0, REG_COUNT, 16'hfffd);
		write_reg(2'd0, REG_TARGET, CNT_MAX);
		repeat (2) offer_op(OP_CPU_TICK, 1'b0);
		repeat (2) read_reg(2'd0, REG_MODE);

		write_reg(2'd1, REG_MODE, TOGGLE_RST);
		write_reg(2'd1, REG_TARGET, 16'd1);
		offer_op(OP_HBLANK, 1'b1);
		offer_op(OP_HBLANK, 1'b1);
		offer_op(OP_HBLANK, 1'b0);
		offer_op(OP_HBLANK, 1'b1);

		write_reg(2'd2, REG_MODE, PULSE_RST_DIV);
		write_reg(2'd2, REG_TARGET, 16'd1);
		repeat (8) offer_op(OP_CPU_TICK, 1'b1);

		offer(OP_SPARE_A, 2'd1, REG_MODE, 16'hffff, 1'b1);
		write_reg(CH_NONE, REG_COUNT, 16'hffff);
		read_reg(2'd1, REG_NONE);

		while (items_sent < N_ITEMS) begin
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(3, 10))
					offer(3'($urandom), 2'($urandom), 2'($urandom), 16'($urandom),
						1'($urandom));
			else
				timer_scenario();
		end
		in_valid <= 1'b0;

		while (outstanding != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
